@@ sv/pesc_pkg.sv @@
// ----------------------------------------------------------------------------
// pesc_pkg
// Shared types and constants for the polygon edge side classifier.
// ----------------------------------------------------------------------------
package pesc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int RESULT_LIMIT   = 63;
  localparam int COORD_W        = 8;
  localparam int EDGE_IDX_W     = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_SIDE_RIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_CLOSED      = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               point_last;
  } in_item_t;

  typedef struct packed {
    logic                  edge_flag;
    logic [EDGE_IDX_W-1:0] edge_index;
    logic                  not_closed;
    logic                  overflowed;
    logic                  result_last;
  } out_item_t;

  // stored point: y in the high byte, x in the low byte
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic wr_en;
    logic edge_load;
    logic scan_eval;
    logic scan_self;
    logic vsr;
  } dp_cmd_t;

  typedef struct packed {
    logic closed;
    logic flag;
  } dp_status_t;

endpackage

@@ sv/pesc_dp.sv @@
// ----------------------------------------------------------------------------
// pesc_dp
// Point memory, tested-edge registers and crossing parity scan.
// ----------------------------------------------------------------------------
module pesc_dp #(
  parameter int MAX_POINTS = pesc_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pesc_pkg::dp_cmd_t   cmd,
  input  logic [AW-1:0]       wr_addr,
  input  pesc_pkg::point_t    wr_data,
  input  logic [AW-1:0]       rd_addr_a,
  input  logic [AW-1:0]       rd_addr_b,
  output pesc_pkg::dp_status_t status
);

  localparam int CW = pesc_pkg::COORD_W;

  pesc_pkg::point_t mem [MAX_POINTS];
  pesc_pkg::point_t rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // tested edge
  logic [CW-1:0] cx_r, cy_r, minx_r, maxx_r, miny_r;
  logic          down_r, left_r, right_r;
  logic          pd_r, pl_r, pr_r, skip_r;

  logic [CW-1:0] x1, y1, x2, y2;
  logic [CW:0]   sx, sy;
  logic          down_nxt, left_nxt, right_nxt;

  always_comb begin
    x1 = rd_a_r.x;
    y1 = rd_a_r.y;
    x2 = rd_b_r.x;
    y2 = rd_b_r.y;
    sx = {1'b0, x1} + {1'b0, x2};
    sy = {1'b0, y1} + {1'b0, y2};
    down_nxt  = 1'b0;
    left_nxt  = 1'b0;
    right_nxt = 1'b0;
    if (y1 == y2) begin
      down_nxt = 1'b1;
    end else if (x1 == x2) begin
      right_nxt = cmd.vsr;
      left_nxt  = !cmd.vsr;
    end else begin
      down_nxt = 1'b1;
      if ((x1 < x2) == (y1 < y2)) begin
        left_nxt = 1'b1;
      end else begin
        right_nxt = 1'b1;
      end
    end
  end

  // other edge against the tested one
  logic span_x, span_y;

  always_comb begin
    span_x = (cx_r >= x1 && cx_r <= x2) || (cx_r >= x2 && cx_r <= x1);
    span_y = (cy_r >= y1 && cy_r <= y2) || (cy_r >= y2 && cy_r <= y1);
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      cx_r    <= sx[CW:1];
      cy_r    <= sy[CW:1];
      minx_r  <= (x1 < x2) ? x1 : x2;
      maxx_r  <= (x1 > x2) ? x1 : x2;
      miny_r  <= (y1 < y2) ? y1 : y2;
      down_r  <= down_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r   <= 1'b0;
      pl_r   <= 1'b0;
      pr_r   <= 1'b0;
      skip_r <= 1'b0;
    end else if (cmd.edge_load) begin
      pd_r   <= 1'b0;
      pl_r   <= 1'b0;
      pr_r   <= 1'b0;
      skip_r <= 1'b0;
    end else if (cmd.scan_eval) begin
      priority if (skip_r) begin
        skip_r <= 1'b0;
      end else if (cmd.scan_self) begin
        skip_r <= 1'b0;
      end else if (span_x) begin
        if (down_r && y1 > miny_r && y2 > miny_r) begin
          pd_r <= !pd_r;
        end
        skip_r <= (cx_r == x2);
      end else if (span_y) begin
        if (left_r && x1 < maxx_r && x2 < maxx_r) begin
          pl_r <= !pl_r;
        end
        if (right_r && x1 > minx_r && x2 > minx_r) begin
          pr_r <= !pr_r;
        end
        skip_r <= (cy_r == y2);
      end else begin
        skip_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.closed = (rd_a_r == rd_b_r);
    status.flag   = !((down_r ? pd_r : 1'b1) &
                      (left_r ? pl_r : 1'b1) &
                      (right_r ? pr_r : 1'b1));
  end

endmodule

@@ sv/pesc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pesc_ctrl
// Sequencer: point loading, closure check, per-edge scan and result output.
// ----------------------------------------------------------------------------
module pesc_ctrl #(
  parameter int MAX_POINTS = pesc_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pesc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pesc_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [pesc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pesc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pesc_pkg::dp_cmd_t                   cmd,
  output logic [AW-1:0]                       wr_addr,
  output pesc_pkg::point_t                    wr_data,
  output logic [AW-1:0]                       rd_addr_a,
  output logic [AW-1:0]                       rd_addr_b,
  input  pesc_pkg::dp_status_t                status
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [7:0] {
    ST_LOAD       = 8'b0000_0001,
    ST_CLOSE_RD   = 8'b0000_0010,
    ST_CLOSE_CHK  = 8'b0000_0100,
    ST_ERR_OUT    = 8'b0000_1000,
    ST_EDGE_RD    = 8'b0001_0000,
    ST_EDGE_LATCH = 8'b0010_0000,
    ST_SCAN       = 8'b0100_0000,
    ST_OUT        = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, tot_r, tot_nxt;
  logic          ov_r, ov_nxt, ovl_r, ovl_nxt;
  logic [AW-1:0] e_r, e_nxt, j_r, j_nxt;
  logic          vsr_r, req_r;

  logic          accept, full, last_edge, last_scan;
  logic [CW-1:0] cnt_inc, j_p1, j_p2, e_p1, last_idx;

  always_comb begin
    accept    = in_valid && !in_stall;
    full      = (cnt_r == CW'(MAX_POINTS));
    cnt_inc   = cnt_r + CW'(1);
    j_p1      = CW'(j_r) + CW'(1);
    j_p2      = CW'(j_r) + CW'(2);
    e_p1      = CW'(e_r) + CW'(1);
    last_idx  = tot_r - CW'(2);
    last_edge = (CW'(e_r) == last_idx) || (int'(e_r) == pesc_pkg::RESULT_LIMIT - 1);
    last_scan = (CW'(j_r) == last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsr_r <= 1'b0;
      req_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pesc_pkg::CFG_VERTICAL_SIDE_RIGHT: vsr_r <= cfg_data[0];
        pesc_pkg::CFG_REQUIRE_CLOSED:      req_r <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tot_nxt   = tot_r;
    ov_nxt    = ov_r;
    ovl_nxt   = ovl_r;
    e_nxt     = e_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.vsr   = vsr_r;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = '{y: in_item.point_y, x: in_item.point_x};
    rd_addr_a = '0;
    rd_addr_b = '0;
    in_stall  = (state_r != ST_LOAD);
    out_valid = (state_r == ST_OUT) || (state_r == ST_ERR_OUT);

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            cmd.wr_en = 1'b1;
            cnt_nxt   = cnt_inc;
          end else begin
            ov_nxt = 1'b1;
          end
          if (in_item.point_last) begin
            tot_nxt = cnt_nxt;
            ovl_nxt = ov_nxt;
            cnt_nxt = '0;
            ov_nxt  = 1'b0;
            if (tot_nxt >= CW'(2)) begin
              state_nxt = ST_CLOSE_RD;
            end
          end
        end
      end
      ST_CLOSE_RD: begin
        rd_addr_a = '0;
        rd_addr_b = AW'(tot_r - CW'(1));
        state_nxt = ST_CLOSE_CHK;
      end
      ST_CLOSE_CHK: begin
        e_nxt = '0;
        if (req_r && !status.closed) begin
          state_nxt = ST_ERR_OUT;
        end else begin
          state_nxt = ST_EDGE_RD;
        end
      end
      ST_ERR_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_EDGE_RD: begin
        rd_addr_a = e_r;
        rd_addr_b = e_p1[AW-1:0];
        state_nxt = ST_EDGE_LATCH;
      end
      ST_EDGE_LATCH: begin
        cmd.edge_load = 1'b1;
        rd_addr_a     = '0;
        rd_addr_b     = AW'(1);
        j_nxt         = '0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_eval = 1'b1;
        cmd.scan_self = (j_r == e_r);
        rd_addr_a     = j_p1[AW-1:0];
        rd_addr_b     = j_p2[AW-1:0];
        if (last_scan) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt = j_p1[AW-1:0];
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (last_edge) begin
            state_nxt = ST_LOAD;
          end else begin
            e_nxt     = e_p1[AW-1:0];
            state_nxt = ST_EDGE_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_item.edge_flag   = (state_r == ST_OUT) && status.flag;
    out_item.edge_index  = (state_r == ST_OUT) ? pesc_pkg::EDGE_IDX_W'(e_r) : '0;
    out_item.not_closed  = (state_r == ST_ERR_OUT);
    out_item.overflowed  = ovl_r;
    out_item.result_last = (state_r == ST_ERR_OUT) || last_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      tot_r   <= '0;
      ovl_r   <= 1'b0;
      e_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      tot_r   <= tot_nxt;
      ovl_r   <= ovl_nxt;
      e_r     <= e_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

@@ sv/polygon_edge_side_classifier.sv @@
// ----------------------------------------------------------------------------
// polygon_edge_side_classifier
// Loads a polygon outline and flags each edge from crossing parities.
// ----------------------------------------------------------------------------
//  channel  ports                              carries
//  in       in_valid / in_stall / in_item      one outline point
//  out      out_valid / out_stall / out_item   one edge result or closure error
//  cfg      cfg_we / cfg_index / cfg_data      register write, no read-back
//
//  One point is taken per cycle while loading. After the last point of an
//  outline of two or more points, ST_CLOSE_RD and ST_CLOSE_CHK read and
//  check closure; then each edge gets a read of its end points, a setup, a
//  scan of every edge at one per cycle through the two memory read ports,
//  then the output. Points are not taken while an outline is being classified.
//  Reset clears the sequencer, config and parities, not memory or edge regs.
//  A stalled result holds and the scan waits until it is taken.
// ----------------------------------------------------------------------------
module polygon_edge_side_classifier #(
  parameter int MAX_POINTS = pesc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pesc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pesc_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [pesc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pesc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);

  pesc_pkg::dp_cmd_t    cmd;
  pesc_pkg::dp_status_t status;
  pesc_pkg::point_t     wr_data;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;

  pesc_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .status    (status)
  );

  pesc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .status    (status)
  );

endmodule

@@ tb/polygon_edge_side_classifier_checker.sv @@
// ----------------------------------------------------------------------------
// polygon_edge_side_classifier_checker
// Watches the point, result and register ports of the classifier. It keeps
// its own copy of the outline and the register settings, works out the
// expected edge results or closure error when an outline ends, and compares
// every accepted result, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module polygon_edge_side_classifier_checker #(
  parameter int MAX_POINTS = pesc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  pesc_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  pesc_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [pesc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pesc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_seen
);

  pesc_pkg::point_t    outline [MAX_POINTS];
  int                  npoints = 0;
  bit                  dropped = 1'b0;
  bit                  side_right = 1'b0;
  bit                  need_closed = 1'b1;
  pesc_pkg::out_item_t expected_results [$];
  int                  fails = 0;
  int                  checked = 0;

  function automatic bit spans(input logic [7:0] v, input logic [7:0] a,
                               input logic [7:0] b);
    return (v >= a && v <= b) || (v >= b && v <= a);
  endfunction

  // flag of edge e of an outline with the given number of edges
  function automatic logic edge_side_flag(input int e, input int edges);
    pesc_pkg::point_t p1, p2, q1, q2;
    logic [8:0] sum_x, sum_y;
    logic [7:0] cx, cy, maxx, minx, miny;
    bit         down, left, right, skip;
    bit         odd_d, odd_l, odd_r;
    p1 = outline[e];
    p2 = outline[e + 1];
    sum_x = {1'b0, p1.x} + {1'b0, p2.x};
    sum_y = {1'b0, p1.y} + {1'b0, p2.y};
    cx = sum_x[8:1];
    cy = sum_y[8:1];
    maxx = (p1.x > p2.x) ? p1.x : p2.x;
    minx = (p1.x < p2.x) ? p1.x : p2.x;
    miny = (p1.y < p2.y) ? p1.y : p2.y;
    down = 1'b0;
    left = 1'b0;
    right = 1'b0;
    if (p1.y == p2.y) begin
      down = 1'b1;
    end else if (p1.x == p2.x) begin
      if (side_right) right = 1'b1;
      else left = 1'b1;
    end else begin
      down = 1'b1;
      if ((p1.x < p2.x) == (p1.y < p2.y)) left = 1'b1;
      else right = 1'b1;
    end
    skip = 1'b0;
    odd_d = 1'b0;
    odd_l = 1'b0;
    odd_r = 1'b0;
    for (int j = 0; j < edges; j++) begin
      if (skip) begin
        skip = 1'b0;
        continue;
      end
      if (j == e) continue;
      q1 = outline[j];
      q2 = outline[j + 1];
      if (spans(cx, q1.x, q2.x)) begin
        if (down && q1.y > miny && q2.y > miny) odd_d = ~odd_d;
        if (cx == q2.x) skip = 1'b1;
      end else if (spans(cy, q1.y, q2.y)) begin
        if (left && q1.x < maxx && q2.x < maxx) odd_l = ~odd_l;
        if (right && q1.x > minx && q2.x > minx) odd_r = ~odd_r;
        if (cy == q2.y) skip = 1'b1;
      end
    end
    if (!down) odd_d = 1'b1;
    if (!left) odd_l = 1'b1;
    if (!right) odd_r = 1'b1;
    return (odd_d && odd_l && odd_r) ? 1'b0 : 1'b1;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    pesc_pkg::out_item_t want;
    int                  tot;
    int                  edges;
    int                  emit;
    if (!rst_n) begin
      npoints = 0;
      dropped = 1'b0;
      side_right = 1'b0;
      need_closed = 1'b1;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result %h arrived, expected none", $time, out_item);
        end else begin
          want = expected_results.pop_front();
          checked++;
          compare_field("edge_flag", want.edge_flag, out_item.edge_flag);
          compare_field("edge_index", want.edge_index, out_item.edge_index);
          compare_field("not_closed", want.not_closed, out_item.not_closed);
          compare_field("overflowed", want.overflowed, out_item.overflowed);
          compare_field("result_last", want.result_last, out_item.result_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pesc_pkg::CFG_VERTICAL_SIDE_RIGHT: side_right = cfg_data[0];
          pesc_pkg::CFG_REQUIRE_CLOSED:      need_closed = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (npoints < MAX_POINTS) begin
          outline[npoints] = {in_item.point_y, in_item.point_x};
          npoints++;
        end else begin
          dropped = 1'b1;
        end
        if (in_item.point_last) begin
          tot = npoints;
          npoints = 0;
          if (tot >= 2) begin
            if (need_closed && outline[0] != outline[tot - 1]) begin
              want = '0;
              want.not_closed = 1'b1;
              want.overflowed = dropped;
              want.result_last = 1'b1;
              expected_results.push_back(want);
            end else begin
              edges = tot - 1;
              emit = (edges < pesc_pkg::RESULT_LIMIT) ? edges : pesc_pkg::RESULT_LIMIT;
              for (int e = 0; e < emit; e++) begin
                want.edge_flag = edge_side_flag(e, edges);
                want.edge_index = pesc_pkg::EDGE_IDX_W'(e);
                want.not_closed = 1'b0;
                want.overflowed = dropped;
                want.result_last = (e + 1 == emit);
                expected_results.push_back(want);
              end
            end
          end
          dropped = 1'b0;
        end
      end
    end
    mismatches <= fails;
    outstanding <= expected_results.size();
    results_seen <= checked;
  end

endmodule

@@ tb/polygon_edge_side_classifier_test.sv @@
// ----------------------------------------------------------------------------
// polygon_edge_side_classifier_test
// Drives outlines into the classifier: a directed set of extreme, vertical,
// diagonal, unclosed, degenerate and single-point outlines, then random
// outlines under four register settings and four idle/stall patterns,
// including outlines past the point capacity. A checker beside the block
// predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
module polygon_edge_side_classifier_test;

  localparam int QUIET_CYCLES = 2 * (pesc_pkg::MAX_POINTS_DEF + 3);

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  pesc_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  pesc_pkg::out_item_t             out_item;
  logic                            cfg_we = 1'b0;
  logic [pesc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pesc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int points_sent = 0;
  int outlines_sent = 0;
  int overflow_outlines = 0;

  polygon_edge_side_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  polygon_edge_side_classifier_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_point(input logic [7:0] x, input logic [7:0] y, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{point_x: x, point_y: y, point_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    if (last) outlines_sent++;
  endtask

  task automatic write_reg(input logic [pesc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pesc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_coord(input bit grid);
    if (grid) return 8'($urandom_range(0, 4) * 4);
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // closed outlines repeat the first point as the last stored point
  task automatic send_outline(input int n, input bit closed, input bit grid);
    logic [7:0] fx, fy, x, y;
    int         keep_last;
    fx = '0;
    fy = '0;
    keep_last = (n < pesc_pkg::MAX_POINTS_DEF) ? n - 1 : pesc_pkg::MAX_POINTS_DEF - 1;
    if (n > pesc_pkg::MAX_POINTS_DEF) overflow_outlines++;
    for (int k = 0; k < n; k++) begin
      if (closed && k > 0 && k == keep_last) begin
        x = fx;
        y = fy;
      end else begin
        x = pick_coord(grid);
        y = pick_coord(grid);
      end
      if (k == 0) begin
        fx = x;
        fy = y;
      end
      push_point(x, y, k == n - 1);
    end
  endtask

  initial begin
    int idle_plan [4]  = '{0, 81, 0, 15};
    int stall_plan [4] = '{0, 0, 81, 15};
    bit side_plan [4]  = '{1'b1, 1'b0, 1'b1, 1'b0};
    bit close_plan [4] = '{1'b1, 1'b0, 1'b0, 1'b1};
    int phase_start;
    int r;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(pesc_pkg::CFG_VERTICAL_SIDE_RIGHT, 1'b0);
    write_reg(pesc_pkg::CFG_REQUIRE_CLOSED, 1'b1);

    // corner triangle
    push_point(8'd0, 8'd0, 1'b0);
    push_point(8'd255, 8'd0, 1'b0);
    push_point(8'd255, 8'd255, 1'b0);
    push_point(8'd0, 8'd0, 1'b1);
    // open outline, closure error
    push_point(8'd10, 8'd10, 1'b0);
    push_point(8'd20, 8'd30, 1'b0);
    push_point(8'd40, 8'd5, 1'b1);
    // single point, no edges
    push_point(8'd7, 8'd7, 1'b1);
    // zero-length edge
    push_point(8'd5, 8'd5, 1'b0);
    push_point(8'd5, 8'd5, 1'b1);
    // square with vertical edges, left side
    push_point(8'd10, 8'd10, 1'b0);
    push_point(8'd10, 8'd50, 1'b0);
    push_point(8'd50, 8'd50, 1'b0);
    push_point(8'd50, 8'd10, 1'b0);
    push_point(8'd10, 8'd10, 1'b1);
    // diagonal triangle
    push_point(8'd0, 8'd255, 1'b0);
    push_point(8'd128, 8'd0, 1'b0);
    push_point(8'd255, 8'd200, 1'b0);
    push_point(8'd0, 8'd255, 1'b1);
    wait_idle();
    // same square, right side
    write_reg(pesc_pkg::CFG_VERTICAL_SIDE_RIGHT, 1'b1);
    push_point(8'd10, 8'd10, 1'b0);
    push_point(8'd10, 8'd50, 1'b0);
    push_point(8'd50, 8'd50, 1'b0);
    push_point(8'd50, 8'd10, 1'b0);
    push_point(8'd10, 8'd10, 1'b1);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      write_reg(pesc_pkg::CFG_VERTICAL_SIDE_RIGHT, side_plan[p]);
      write_reg(pesc_pkg::CFG_REQUIRE_CLOSED, close_plan[p]);
      phase_start = points_sent;
      if (p == 1) send_outline(66, 1'b1, 1'b0);
      if (p == 3) send_outline(65, 1'b1, 1'b1);
      while (points_sent - phase_start < 75) begin
        r = $urandom_range(0, 99);
        if (r < 8) n = 1;
        else if (r < 80) n = $urandom_range(2, 8);
        else n = $urandom_range(9, 20);
        send_outline(n, $urandom_range(0, 99) < 85, $urandom_range(0, 1));
      end
      wait_idle();
    end

    $display("covered %0d points in %0d outlines, %0d past capacity, over four settings",
             points_sent, outlines_sent, overflow_outlines);
    $display("checked %0d results under four idle and stall patterns", results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("polygon_edge_side_classifier_test passed");
    end else begin
      $display("polygon_edge_side_classifier_test failed");
    end
    $finish;
  end

  initial begin
    #(8 * 500000);
    $display("timeout with %0d results outstanding", outstanding);
    $display("polygon_edge_side_classifier_test failed");
    $finish;
  end

endmodule
